// ----- rtl/svr_pkg.sv -----
// Shared types, constants and helper functions of the pan/tilt servo slew ramp.
// Used by every module of the block; depends on nothing else.
package svr_pkg;

   localparam int PosW      = 16;
   localparam int StepW     = 14;
   localparam int PulseW    = 12;
   localparam int ModeW     = 2;
   localparam int ReqDataW  = 64;
   localparam int RspDataW  = 64;
   localparam int CsrIndexW = 2;

   localparam int PosFracBitsDef    = 14;
   localparam int TicksPerSecondDef = 5;
   localparam int QueueDepthDef     = 2;

   localparam logic [PulseW-1:0] PulseZeroRst = 12'd150;
   localparam logic [PulseW-1:0] PulseFullRst = 12'd650;

   localparam logic [ModeW-1:0] ModeTick = 2'd0;
   localparam logic [ModeW-1:0] ModeMove = 2'd1;
   localparam logic [ModeW-1:0] ModeStop = 2'd2;

   localparam logic [CsrIndexW-1:0] CsrPulseZero = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrPulseFull = 2'd1;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_MOVE,
      CMD_STOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic signed [PosW-1:0]   goal_x;
      logic signed [PosW-1:0]   goal_y;
      logic signed [StepW-1:0]  step_x;
      logic signed [StepW-1:0]  step_y;
   } cmd_type;

   typedef struct packed {
      logic [PulseW-1:0] zero;
      logic [PulseW-1:0] full;
   } pulse_cfg_type;

   // Largest position magnitude: one in fixed point, held inside the 16-bit range.
   function automatic logic signed [PosW:0] pos_limit(input int frac_bits);
      logic signed [PosW:0] lim;
      if (frac_bits >= PosW - 1) begin
         lim = (PosW+1)'((1 << (PosW - 1)) - 1);
      end else begin
         lim = (PosW+1)'(1 << frac_bits);
      end
      return lim;
   endfunction

   function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW:0] v,
                                                      input logic signed [PosW:0] lim);
      logic signed [PosW:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r[PosW-1:0];
   endfunction

endpackage

// ----- rtl/svr_front.sv -----
// Front end of the servo ramp: takes request transfers, sorts them by mode and
// turns move speeds into per-tick steps. Depends on svr_pkg.
module svr_front #(
   parameter int POS_FRAC_BITS    = svr_pkg::PosFracBitsDef,
   parameter int TICKS_PER_SECOND = svr_pkg::TicksPerSecondDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [svr_pkg::ReqDataW-1:0]   req_tdata,
   input  logic [svr_pkg::ModeW-1:0]      req_tuser,
   output logic                           push_valid,
   output svr_pkg::cmd_type               push_cmd,
   input  logic                           push_ready
);

   localparam int PosW   = svr_pkg::PosW;
   localparam int StepW  = svr_pkg::StepW;
   localparam int MagW   = PosW;
   localparam int RecipW = 32;
   localparam int MulW   = MagW + RecipW;
   localparam int TpsW   = $clog2(TICKS_PER_SECOND + 1);
   localparam int RemW   = MagW + TpsW;
   localparam int QW     = MagW + 1;
   localparam int SW     = QW + 1;
   localparam longint unsigned RecipFull =
      ((64'd1 << RecipW) - 64'd1) / longint'(TICKS_PER_SECOND);
   localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
   localparam logic [TpsW-1:0]   Tps   = TpsW'(TICKS_PER_SECOND);
   localparam int StepMaxInt = (1 << (StepW - 1)) - 1;
   localparam logic signed [SW-1:0] StepHi = SW'(StepMaxInt);
   localparam logic signed [SW-1:0] StepLo = SW'(-StepMaxInt - 1);
   localparam logic signed [PosW:0] PosLim = svr_pkg::pos_limit(POS_FRAC_BITS);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_FIX  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   svr_pkg::cmd_type  cmd_ff, cmd_in;
   logic [MagW-1:0]   mag_ff [2];
   logic [MagW-1:0]   mag_in [2];
   logic              neg_ff [2];
   logic              neg_in [2];
   logic [MagW-1:0]   q0_ff  [2];
   logic [MagW-1:0]   q0_in  [2];

   always_comb begin
      logic [MagW-1:0]          spd;
      logic [MulW-1:0]          mul;
      logic [RemW-1:0]          rem;
      logic [QW-1:0]            q;
      logic signed [SW-1:0]     sq;
      logic signed [StepW-1:0]  st [2];

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      q0_in      = q0_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      spd        = '0;
      mul        = '0;
      rem        = '0;
      q          = '0;
      sq         = '0;
      st[0]      = '0;
      st[1]      = '0;

      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in.goal_x = svr_pkg::sat_pos($signed({req_tdata[15], req_tdata[15:0]}),
                                                PosLim);
               cmd_in.goal_y = svr_pkg::sat_pos($signed({req_tdata[31], req_tdata[31:16]}),
                                                PosLim);
               for (int i = 0; i < 2; i++) begin
                  spd       = req_tdata[32 + i*MagW +: MagW];
                  neg_in[i] = spd[MagW-1];
                  mag_in[i] = spd[MagW-1] ? (~spd + MagW'(1)) : spd;
               end
               unique case (req_tuser)
                  svr_pkg::ModeMove: begin
                     cmd_in.kind = svr_pkg::CMD_MOVE;
                     state_in    = F_MUL;
                  end
                  svr_pkg::ModeTick: begin
                     cmd_in.kind = svr_pkg::CMD_TICK;
                     state_in    = F_PUSH;
                  end
                  svr_pkg::ModeStop: begin
                     cmd_in.kind = svr_pkg::CMD_STOP;
                     state_in    = F_PUSH;
                  end
                  default: begin
                     state_in = F_IDLE;
                  end
               endcase
            end
         end
         F_MUL: begin
            for (int i = 0; i < 2; i++) begin
               mul      = MulW'(mag_ff[i]) * MulW'(Recip);
               q0_in[i] = mul[MulW-1 -: MagW];
            end
            state_in = F_FIX;
         end
         F_FIX: begin
            for (int i = 0; i < 2; i++) begin
               rem = RemW'(mag_ff[i]) - RemW'(q0_ff[i]) * RemW'(Tps);
               q   = QW'(q0_ff[i]) + QW'(rem >= RemW'(Tps));
               sq  = neg_ff[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
               if (sq > StepHi) begin
                  st[i] = StepW'(StepHi);
               end else if (sq < StepLo) begin
                  st[i] = StepW'(StepLo);
               end else begin
                  st[i] = sq[StepW-1:0];
               end
            end
            cmd_in.step_x = st[0];
            cmd_in.step_y = st[1];
            state_in      = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_cmd = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      q0_ff  <= q0_in;
   end

endmodule

// ----- rtl/svr_queue.sv -----
// Short command queue between the front end and the motion back end of the
// servo ramp, built from registers. Depends on svr_pkg.
module svr_queue #(
   parameter int DEPTH = svr_pkg::QueueDepthDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  svr_pkg::cmd_type  push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output svr_pkg::cmd_type  pop_cmd,
   input  logic              pop_ready
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   svr_pkg::cmd_type  mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (cnt_ff != CntW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/svr_back.sv -----
// Motion back end of the servo ramp: holds axis state, steps the axes on ticks
// and works out the servo pulse counts into the result register. Depends on svr_pkg.
module svr_back #(
   parameter int POS_FRAC_BITS = svr_pkg::PosFracBitsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  svr_pkg::pulse_cfg_type        cfg,
   input  logic                          pop_valid,
   input  svr_pkg::cmd_type              pop_cmd,
   output logic                          pop_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [svr_pkg::RspDataW-1:0]  rsp_tdata
);

   localparam int PosW     = svr_pkg::PosW;
   localparam int StepW    = svr_pkg::StepW;
   localparam int PulseW   = svr_pkg::PulseW;
   localparam int NumW     = 32;
   localparam int AngW     = 9;
   localparam int DiffW    = PulseW + 1;
   localparam int ProdW    = DiffW + AngW;
   localparam int MagW     = ProdW - 1;
   localparam int RecipW   = 32;
   localparam int MulW     = MagW + RecipW;
   localparam int QW       = 13;
   localparam int ResW     = PulseW + 2;
   localparam int PadW     = svr_pkg::RspDataW - (2*PosW + 2*PulseW + 2);
   localparam int DivInt   = 180;
   localparam logic [MagW-1:0] Div = MagW'(DivInt);
   localparam longint unsigned RecipFull = ((64'd1 << RecipW) - 64'd1) / longint'(DivInt);
   localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
   localparam logic signed [NumW-1:0] NinetyScaled = NumW'(90 * (1 << POS_FRAC_BITS));
   localparam logic signed [NumW-1:0] K45 = NumW'(45);
   localparam int PulseMaxInt = (1 << PulseW) - 1;
   localparam logic signed [ResW-1:0] PulseMax = ResW'(PulseMaxInt);
   localparam logic signed [PosW:0] PosLim = svr_pkg::pos_limit(POS_FRAC_BITS);

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_ANGLE = 5'b00010,
      B_PROD  = 5'b00100,
      B_RECIP = 5'b01000,
      B_FIX   = 5'b10000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic signed [PosW-1:0]         pos_ff  [2];
   logic signed [PosW-1:0]         pos_in  [2];
   logic signed [PosW-1:0]         goal_ff [2];
   logic signed [PosW-1:0]         goal_in [2];
   logic signed [StepW-1:0]        step_ff [2];
   logic signed [StepW-1:0]        step_in [2];
   logic [1:0]                     act_ff, act_in;
   logic signed [AngW-1:0]         ang_ff  [2];
   logic signed [AngW-1:0]         ang_in  [2];
   logic                           pneg_ff [2];
   logic                           pneg_in [2];
   logic [MagW-1:0]                pmag_ff [2];
   logic [MagW-1:0]                pmag_in [2];
   logic [QW-1:0]                  q0_ff   [2];
   logic [QW-1:0]                  q0_in   [2];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [svr_pkg::RspDataW-1:0]   rsp_data_ff, rsp_data_in;
   logic [PulseW-1:0]              pulse   [2];

   // Final correction of the reciprocal quotient, offset and saturation.
   always_comb begin
      logic [MagW-1:0]         rem;
      logic [QW-1:0]           q;
      logic signed [ResW-1:0]  sq;
      logic signed [ResW-1:0]  res;

      for (int i = 0; i < 2; i++) begin
         rem = pmag_ff[i] - MagW'(q0_ff[i]) * Div;
         q   = q0_ff[i] + QW'(rem >= Div);
         sq  = pneg_ff[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
         res = sq + $signed({2'b00, cfg.zero});
         if (res < 0) begin
            pulse[i] = '0;
         end else if (res > PulseMax) begin
            pulse[i] = PulseW'(PulseMax);
         end else begin
            pulse[i] = res[PulseW-1:0];
         end
      end
   end

   always_comb begin
      logic signed [PosW:0]    sum;
      logic signed [PosW-1:0]  p;
      logic signed [NumW-1:0]  num;
      logic signed [NumW-1:0]  shifted;
      logic signed [DiffW-1:0] diff;
      logic signed [ProdW-1:0] pr;
      logic [MulW-1:0]         mul;

      state_in     = state_ff;
      pos_in       = pos_ff;
      goal_in      = goal_ff;
      step_in      = step_ff;
      act_in       = act_ff;
      ang_in       = ang_ff;
      pneg_in      = pneg_ff;
      pmag_in      = pmag_ff;
      q0_in        = q0_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      sum          = '0;
      p            = '0;
      num          = '0;
      shifted      = '0;
      mul          = '0;
      diff         = $signed({1'b0, cfg.full}) - $signed({1'b0, cfg.zero});
      pr           = '0;

      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               case (pop_cmd.kind)
                  svr_pkg::CMD_MOVE: begin
                     goal_in[0] = pop_cmd.goal_x;
                     goal_in[1] = pop_cmd.goal_y;
                     step_in[0] = pop_cmd.step_x;
                     step_in[1] = pop_cmd.step_y;
                     act_in     = 2'b11;
                  end
                  svr_pkg::CMD_STOP: begin
                     act_in = 2'b00;
                  end
                  svr_pkg::CMD_TICK: begin
                     if (|act_ff) begin
                        for (int i = 0; i < 2; i++) begin
                           if (act_ff[i] && (step_ff[i] != '0)) begin
                              sum = {pos_ff[i][PosW-1], pos_ff[i]} + (PosW+1)'(step_ff[i]);
                              p   = svr_pkg::sat_pos(sum, PosLim);
                              if (((step_ff[i] > 0) && (p > goal_ff[i])) ||
                                  ((step_ff[i] < 0) && (p < goal_ff[i]))) begin
                                 p         = goal_ff[i];
                                 act_in[i] = 1'b0;
                              end
                              pos_in[i] = p;
                           end
                        end
                        state_in = B_ANGLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_ANGLE: begin
            for (int i = 0; i < 2; i++) begin
               num       = NinetyScaled - NumW'(pos_ff[i]) * K45;
               shifted   = num >>> POS_FRAC_BITS;
               ang_in[i] = shifted[AngW-1:0];
            end
            state_in = B_PROD;
         end
         B_PROD: begin
            for (int i = 0; i < 2; i++) begin
               pr         = ProdW'(diff) * ProdW'(ang_ff[i]);
               pneg_in[i] = pr[ProdW-1];
               pmag_in[i] = pr[ProdW-1] ? MagW'(-pr) : MagW'(pr);
            end
            state_in = B_RECIP;
         end
         B_RECIP: begin
            for (int i = 0; i < 2; i++) begin
               mul      = MulW'(pmag_ff[i]) * MulW'(Recip);
               q0_in[i] = mul[RecipW +: QW];
            end
            state_in = B_FIX;
         end
         B_FIX: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PadW'(0), act_ff[1], act_ff[0], pulse[1], pulse[0],
                               pos_ff[1], pos_ff[0]};
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pos_ff       <= '{default: '0};
         goal_ff      <= '{default: '0};
         step_ff      <= '{default: '0};
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         goal_ff      <= goal_in;
         step_ff      <= step_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff      <= ang_in;
      pneg_ff     <= pneg_in;
      pmag_ff     <= pmag_in;
      q0_ff       <= q0_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/two_axis_servo_slew_ramp.sv -----
// Top level of the two-axis pan/tilt servo slew ramp: configuration registers,
// front end, command queue and motion back end. Depends on svr_pkg, svr_front,
// svr_queue and svr_back.
//
// Usage. Requests arrive on the req_ stream; req_tuser carries the mode (tick,
// move, stop; the unused code is dropped). A move stores targets and per-tick
// steps, a stop halts both axes, and a tick while an axis moves produces one
// rsp_ transfer with both positions, both pulse counts and both moving flags.
// Idle ticks, moves and stops produce no result. The csr_ channel writes the
// zero-degree and full-degree pulse counts; it is always ready.
// Flow: the front end passes a tick or stop through its idle and push states and
// a move through idle, reciprocal multiply, correction and push, and takes no new
// request until the command is pushed. The back end handles a move, stop or idle
// tick in its idle state; a moving tick runs through its step, angle, product,
// reciprocal and correction registers in series. A two-entry queue separates
// the two halves, and the result register holds one finished result, so new
// requests are still taken while rsp_tready is low until the queue fills.
// Reset returns both axes to center, stops them and reloads the pulse counts.
module two_axis_servo_slew_ramp #(
   parameter int POS_FRAC_BITS    = svr_pkg::PosFracBitsDef,
   parameter int TICKS_PER_SECOND = svr_pkg::TicksPerSecondDef,
   parameter int QUEUE_DEPTH      = svr_pkg::QueueDepthDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // target_x, target_y, speed_x, speed_y
   input  logic [svr_pkg::ReqDataW-1:0]    req_tdata,
   // mode
   input  logic [svr_pkg::ModeW-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pos_x, pos_y, pulse_x, pulse_y, still_moving_x, still_moving_y, zero fill
   output logic [svr_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [svr_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [svr_pkg::PulseW-1:0]      csr_data
);

   svr_pkg::pulse_cfg_type  cfg_ff, cfg_in;
   logic                    push_valid;
   logic                    push_ready;
   svr_pkg::cmd_type        push_cmd;
   logic                    pop_valid;
   logic                    pop_ready;
   svr_pkg::cmd_type        pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            svr_pkg::CsrPulseZero: cfg_in.zero = csr_data;
            svr_pkg::CsrPulseFull: cfg_in.full = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero <= svr_pkg::PulseZeroRst;
         cfg_ff.full <= svr_pkg::PulseFullRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   svr_front #(
      .POS_FRAC_BITS    (POS_FRAC_BITS),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   svr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   svr_back #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/svr_checker.sv -----
// Port-level checks of the servo ramp, attached to the top level by bind.
// Depends on svr_pkg and two_axis_servo_slew_ramp.
module svr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [svr_pkg::ModeW-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [svr_pkg::RspDataW-1:0]    rsp_tdata
);

   // Coming out of reset the block has no result and takes a request.
   a_reset_state : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty and ready after reset");

   // A stalled result stays and keeps its data.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

   // A transfer with a defined mode keeps the front end busy in the next cycle.
   a_front_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser == svr_pkg::ModeTick || req_tuser == svr_pkg::ModeMove ||
        req_tuser == svr_pkg::ModeStop)) |=> !req_tready)
      else $error("front end took a request while still busy");

   // The fill bits above the result fields are zero.
   a_rsp_fill : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[svr_pkg::RspDataW-1:58] == '0))
      else $error("result fill bits not zero");

endmodule

bind two_axis_servo_slew_ramp svr_checker u_checker (.*);
